/* sv/utn_pkg.sv */
// utn_pkg: shared types, character constants and the latin-1 fold table
// for the text normaliser core. No dependencies.

package utn_pkg;

    localparam int CODE_BITS      = 21;
    localparam int TOTAL_BITS     = 32;
    localparam int MAX_CHARS      = 5;
    localparam int RUN_BITS       = 3;
    localparam int CFG_INDEX_BITS = 2;

    // configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] CFG_REMOVE_ENABLE  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_REPLACE_ENABLE = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_FOLD_ENABLE    = 2'd2;

    // plain replacement characters
    localparam logic [CODE_BITS-1:0] CH_LF    = 21'h00000A;
    localparam logic [CODE_BITS-1:0] CH_SPACE = 21'h000020;
    localparam logic [CODE_BITS-1:0] CH_QUOTE = 21'h000022;
    localparam logic [CODE_BITS-1:0] CH_TICK  = 21'h000027;
    localparam logic [CODE_BITS-1:0] CH_DASH  = 21'h00002D;
    localparam logic [CODE_BITS-1:0] CH_DOT   = 21'h00002E;
    localparam logic [CODE_BITS-1:0] CH_SLASH = 21'h00002F;
    localparam logic [CODE_BITS-1:0] CH_WAW   = 21'h000648;

    typedef struct packed {
        logic [CODE_BITS-1:0] code_point;
        logic                 first_of_text;
    } in_item_t;

    typedef struct packed {
        logic [CODE_BITS-1:0]  out_char;
        logic                  last_of_run;
        logic [TOTAL_BITS-1:0] change_total;
    } out_item_t;

    typedef logic [MAX_CHARS-1:0][CODE_BITS-1:0] char_run_t;

    // classifier verdict for one code point
    typedef struct packed {
        logic                drop;
        logic                bump;
        logic [RUN_BITS-1:0] n;
        char_run_t           chars;
    } cls_t;

    // fold of 0xC0..0xFF: {first, second}; zero first means no fold,
    // zero second means a single letter
    function automatic logic [15:0] fold_pair(input logic [5:0] idx);
        logic [15:0] r;
        r = 16'h0000;
        case (idx)
            6'h00, 6'h01, 6'h02, 6'h03, 6'h04, 6'h05:  r = {8'h41, 8'h00};
            6'h06:                                     r = {8'h41, 8'h45};
            6'h08, 6'h09, 6'h0A, 6'h0B:                r = {8'h45, 8'h00};
            6'h0C, 6'h0D, 6'h0E, 6'h0F:                r = {8'h49, 8'h00};
            6'h11:                                     r = {8'h4E, 8'h00};
            6'h12, 6'h13, 6'h14, 6'h15, 6'h16, 6'h18:  r = {8'h4F, 8'h00};
            6'h19, 6'h1A, 6'h1B, 6'h1C:                r = {8'h55, 8'h00};
            6'h1D:                                     r = {8'h59, 8'h00};
            6'h1F:                                     r = {8'h73, 8'h73};
            6'h21, 6'h22, 6'h23, 6'h24, 6'h25:         r = {8'h61, 8'h00};
            6'h26:                                     r = {8'h61, 8'h65};
            6'h27:                                     r = {8'h63, 8'h00};
            6'h28, 6'h29, 6'h2A, 6'h2B:                r = {8'h65, 8'h00};
            6'h2C, 6'h2D, 6'h2E, 6'h2F:                r = {8'h69, 8'h00};
            6'h31:                                     r = {8'h6E, 8'h00};
            6'h32, 6'h33, 6'h34, 6'h35, 6'h36, 6'h38:  r = {8'h6F, 8'h00};
            6'h39, 6'h3A, 6'h3B, 6'h3C:                r = {8'h75, 8'h00};
            6'h3D, 6'h3F:                              r = {8'h79, 8'h00};
            default:                                   r = 16'h0000;
        endcase
        return r;
    endfunction

endpackage

/* sv/unicode_text_normalizer_core.sv */
// Text normaliser core: input register, classifier and counter, expansion
// buffer with result register. The first result of an item passes the input
// register, the expansion buffer and the result register. One item per cycle
// while the output is not stalled and each gives at most one character; an
// item of n characters gives n results, a dropped item leaves no result.
// Reset (aresetn low, synchronous) empties all stages, clears the counter
// and sets remove and replace on, fold off.

module unicode_text_normalizer_core import utn_pkg::*; #(
    parameter int COUNT_BITS = 32
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  in_item_t                  s_item,
    output logic                      m_valid,
    input  logic                      m_ready,
    output out_item_t                 m_item,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [0:0]                cfg_wdata
);

    logic                  remove_en_reg, replace_en_reg, fold_en_reg;
    logic                  a_valid_reg, a_valid_next;
    in_item_t              a_item_reg;
    logic [COUNT_BITS-1:0] cnt_reg, cnt_next;
    logic [COUNT_BITS-1:0] cnt_base;
    logic [63:0]           cnt_wide;
    cls_t                  cls;
    logic                  load_ready;
    logic                  a_take;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            remove_en_reg  <= 1'b1;
            replace_en_reg <= 1'b1;
            fold_en_reg    <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_REMOVE_ENABLE:  remove_en_reg  <= cfg_wdata[0];
                CFG_REPLACE_ENABLE: replace_en_reg <= cfg_wdata[0];
                CFG_FOLD_ENABLE:    fold_en_reg    <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    utn_classify u_classify (
        .code_point (a_item_reg.code_point),
        .remove_en  (remove_en_reg),
        .replace_en (replace_en_reg),
        .fold_en    (fold_en_reg),
        .cls        (cls)
    );

    // input stage hand-off
    assign a_take  = a_valid_reg && (cls.drop || load_ready);
    assign s_ready = !a_valid_reg || a_take;

    always_comb begin
        a_valid_next = a_valid_reg;
        if (s_valid && s_ready)
            a_valid_next = 1'b1;
        else if (a_take)
            a_valid_next = 1'b0;
    end

    // saturating change counter, cleared at the start of a text
    assign cnt_base = a_item_reg.first_of_text ? '0 : cnt_reg;

    always_comb begin
        cnt_next = cnt_reg;
        if (a_take) begin
            cnt_next = cnt_base;
            if (cls.bump && cnt_base != {COUNT_BITS{1'b1}})
                cnt_next = COUNT_BITS'(cnt_base + 1'b1);
        end
    end

    assign cnt_wide = 64'(cnt_next);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            cnt_reg     <= '0;
        end else begin
            a_valid_reg <= a_valid_next;
            cnt_reg     <= cnt_next;
        end
        if (s_valid && s_ready)
            a_item_reg <= s_item;
    end

    utn_expand u_expand (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load_valid (a_valid_reg && !cls.drop),
        .load_n     (cls.n),
        .load_chars (cls.chars),
        .load_total (cnt_wide[TOTAL_BITS-1:0]),
        .load_ready (load_ready),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_item     (m_item)
    );

endmodule

/* sv/utn_classify.sv */
// utn_classify: decides drop, replacement, fold or pass-through for one
// code point and builds the output characters. Depends on utn_pkg.

module utn_classify import utn_pkg::*; (
    input  logic [CODE_BITS-1:0] code_point,
    input  logic                 remove_en,
    input  logic                 replace_en,
    input  logic                 fold_en,
    output cls_t                 cls
);

    logic                 harmful;
    logic                 is_space;
    logic                 is_line;
    logic                 is_dash;
    logic                 is_tick;
    logic [RUN_BITS-1:0]  rep_n;
    char_run_t            rep_chars;
    logic [15:0]          fold;
    logic                 fold_hit;
    logic [CODE_BITS-1:0] c;

    assign c = code_point;

    // harmful control, format and non-character codes
    assign harmful = (c < 21'h09) || (c == 21'h0B) || (c == 21'h0C) ||
                     (c >= 21'h0E && c <= 21'h1F) ||
                     (c >= 21'h7F && c <= 21'h84) ||
                     (c >= 21'h86 && c <= 21'h9F) ||
                     (c == 21'hAD) || (c == 21'h34F) || (c == 21'h640) ||
                     (c >= 21'h206A && c <= 21'h206F) ||
                     (c >= 21'h2FF0 && c <= 21'h2FFB) ||
                     (c == 21'h303E) ||
                     (c >= 21'hFDD0 && c <= 21'hFDEF) ||
                     (c >= 21'hFE00 && c <= 21'hFE0F) ||
                     (c == 21'hFEFF) ||
                     (c >= 21'hFFF9 && c <= 21'hFFFC) ||
                     (c == 21'hFFFE) || (c == 21'hFFFF);

    assign is_space = (c == 21'hA0) || (c >= 21'h2000 && c <= 21'h200F) ||
                      (c >= 21'h202A && c <= 21'h202F) ||
                      (c >= 21'h205F && c <= 21'h2063);
    assign is_line  = (c == 21'h85) || (c == 21'h2028);
    assign is_dash  = (c >= 21'h2010 && c <= 21'h2015) || (c == 21'h2043);
    assign is_tick  = (c >= 21'h2018 && c <= 21'h201B) || (c == 21'h2032) ||
                      (c == 21'h2035);

    // replacement sequences
    always_comb begin
        rep_n     = 3'd0;
        rep_chars = '0;
        if (is_space) begin
            rep_n = 3'd1; rep_chars[0] = CH_SPACE;
        end else if (is_line) begin
            rep_n = 3'd1; rep_chars[0] = CH_LF;
        end else if (c == 21'h2029) begin
            rep_n = 3'd2; rep_chars[0] = CH_LF; rep_chars[1] = CH_LF;
        end else if (is_dash) begin
            rep_n = 3'd1; rep_chars[0] = CH_DASH;
        end else if (is_tick) begin
            rep_n = 3'd1; rep_chars[0] = CH_TICK;
        end else if (c >= 21'h201C && c <= 21'h201F) begin
            rep_n = 3'd1; rep_chars[0] = CH_QUOTE;
        end else if (c == 21'h2026) begin
            rep_n        = 3'd5;
            rep_chars[0] = CH_SPACE;
            rep_chars[1] = CH_DOT;
            rep_chars[2] = CH_DOT;
            rep_chars[3] = CH_DOT;
            rep_chars[4] = CH_SPACE;
        end else if (c == 21'h2033 || c == 21'h2036) begin
            rep_n = 3'd2; rep_chars[0] = CH_TICK; rep_chars[1] = CH_TICK;
        end else if (c == 21'h2034 || c == 21'h2037) begin
            rep_n        = 3'd3;
            rep_chars[0] = CH_TICK;
            rep_chars[1] = CH_TICK;
            rep_chars[2] = CH_TICK;
        end else if (c == 21'h2044) begin
            rep_n = 3'd1; rep_chars[0] = CH_SLASH;
        end else if (c == 21'hFEED || c == 21'hFEEE) begin
            rep_n = 3'd1; rep_chars[0] = CH_WAW;
        end
    end

    // latin-1 fold lookup
    assign fold     = fold_pair(c[5:0]);
    assign fold_hit = (c >= 21'hC0) && (c <= 21'hFF) && (fold[15:8] != 8'h00);

    // stage priority: remove, replace, fold, pass-through
    always_comb begin
        cls.drop  = 1'b0;
        cls.bump  = 1'b0;
        cls.n     = 3'd1;
        cls.chars = '0;
        cls.chars[0] = c;
        if (remove_en && harmful) begin
            cls.drop = 1'b1;
            cls.bump = 1'b1;
            cls.n    = 3'd0;
        end else if (replace_en && rep_n != 3'd0) begin
            cls.bump  = 1'b1;
            cls.n     = rep_n;
            cls.chars = rep_chars;
        end else if (fold_en && fold_hit) begin
            cls.chars[0] = {13'd0, fold[15:8]};
            if (fold[7:0] != 8'h00) begin
                cls.n        = 3'd2;
                cls.chars[1] = {13'd0, fold[7:0]};
            end
        end
    end

endmodule

/* sv/utn_expand.sv */
// utn_expand: holds the characters of one item and hands them out one per
// cycle through the result register unless stalled. Depends on utn_pkg.

module utn_expand import utn_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  load_valid,
    input  logic [RUN_BITS-1:0]   load_n,
    input  char_run_t             load_chars,
    input  logic [TOTAL_BITS-1:0] load_total,
    output logic                  load_ready,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_item
);

    char_run_t             chars_reg, chars_next;
    logic [RUN_BITS-1:0]   rem_reg, rem_next;
    logic [TOTAL_BITS-1:0] total_reg, total_next;
    logic                  m_valid_reg, m_valid_next;
    out_item_t             m_item_reg, m_item_next;
    logic                  out_adv;

    assign out_adv    = !m_valid_reg || m_ready;
    assign load_ready = (rem_reg == 3'd0) || (rem_reg == 3'd1 && out_adv);

    // emit from the head of the buffer, then reload when free
    always_comb begin
        chars_next   = chars_reg;
        rem_next     = rem_reg;
        total_next   = total_reg;
        m_valid_next = m_valid_reg;
        m_item_next  = m_item_reg;
        if (out_adv) begin
            m_valid_next = (rem_reg != 3'd0);
            if (rem_reg != 3'd0) begin
                m_item_next.out_char     = chars_reg[0];
                m_item_next.last_of_run  = (rem_reg == 3'd1);
                m_item_next.change_total = total_reg;
                chars_next = {{CODE_BITS{1'b0}}, chars_reg[MAX_CHARS-1:1]};
                rem_next   = rem_reg - 3'd1;
            end
        end
        if (load_valid && load_ready) begin
            chars_next = load_chars;
            rem_next   = load_n;
            total_next = load_total;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            rem_reg     <= rem_next;
            m_valid_reg <= m_valid_next;
        end
        chars_reg  <= chars_next;
        total_reg  <= total_next;
        m_item_reg <= m_item_next;
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

/* sv/utn_checker.sv */
// utn_checker: port-level checks on the text normaliser core, bound to the
// top level. Depends on utn_pkg.

module utn_checker import utn_pkg::*; (
    input logic      aclk,
    input logic      aresetn,
    input logic      s_ready,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_item
);

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("result changed while stalled");

    // the block is ready right after reset
    a_ready_after_reset: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(aresetn) |-> s_ready)
        else $error("not ready after reset");

    // a run continues without gaps
    a_run_gapless: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_item.last_of_run |=> m_valid)
        else $error("gap inside a run");

    // all characters of one run carry the same total
    a_run_total: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_item.last_of_run |=>
            m_item.change_total == $past(m_item.change_total))
        else $error("total changed inside a run");

endmodule

bind unicode_text_normalizer_core utn_checker u_utn_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_item  (m_item)
);
